### design/cfc_pkg.sv
// cfc_pkg: shared types and constants for the causal fir convolution unit
// no dependencies; imported by cfc_mac, cfc_ctrl and the top level
package cfc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COEF_FRAC   = 14;
	localparam int IDX_W       = 7;
	localparam int DEF_TAPS    = 128;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} cfc_state_t;

	typedef struct packed {
		logic acc_clear;
		logic issue;
	} cfc_ctl_t;

endpackage

### design/cfc_ram.sv
// cfc_ram: single write port, single read port memory with registered read data
// no package dependencies
module cfc_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int W     = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/cfc_mac.sv
// cfc_mac: shared multiply-accumulate unit with rounding and saturation
// depends on cfc_pkg for sample widths and the control struct
module cfc_mac #(
	parameter int ACC_W = 40
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cfc_pkg::cfc_ctl_t                ctl,
	input  logic [cfc_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic [cfc_pkg::SAMPLE_BITS-1:0]  coef,
	output logic                             busy,
	output logic [cfc_pkg::SAMPLE_BITS-1:0]  result,
	output logic                             sat
);
	import cfc_pkg::*;

	localparam int PW = 2 * SAMPLE_BITS;
	localparam logic signed [ACC_W:0] HALF = (ACC_W+1)'(2 ** (COEF_FRAC - 1));
	localparam logic signed [ACC_W:0] MAXV = (ACC_W+1)'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [ACC_W:0] MINV = -(ACC_W+1)'(2 ** (SAMPLE_BITS - 1));

	logic                    v_s1;
	logic                    v_s2;
	logic signed [PW-1:0]    prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W:0]   rnd;
	logic signed [ACC_W:0]   shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= $signed(sample) * $signed(coef);
		end
		if (ctl.acc_clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// round half up, then floor shift
	always_comb begin
		rnd     = (ACC_W+1)'(acc_q) + HALF;
		shifted = rnd >>> COEF_FRAC;
		sat     = 1'b0;
		result  = shifted[SAMPLE_BITS-1:0];
		if (shifted > MAXV) begin
			sat    = 1'b1;
			result = MAXV[SAMPLE_BITS-1:0];
		end else if (shifted < MINV) begin
			sat    = 1'b1;
			result = MINV[SAMPLE_BITS-1:0];
		end
	end

	assign busy = v_s1 | v_s2;

	a_clear_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_clear |-> !busy)
		else $error("accumulator cleared while products in flight");

	a_no_issue_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_clear |=> !v_s1)
		else $error("tap issued together with accumulator clear");

endmodule

### design/cfc_ctrl.sv
// cfc_ctrl: sequencer for coefficient clearing, loads and the tap loop
// depends on cfc_pkg for states, modes and the control struct
module cfc_ctrl #(
	parameter int TAPS = 128,
	parameter int AW   = 7,
	parameter int CW   = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [cfc_pkg::IDX_W-1:0]   coef_index,
	input  logic                        block_start,
	output logic                        dl_we,
	output logic [AW-1:0]               dl_waddr,
	output logic [AW-1:0]               dl_raddr,
	output logic                        cf_we,
	output logic                        cf_clear,
	output logic [AW-1:0]               cf_waddr,
	output logic [AW-1:0]               cf_raddr,
	output cfc_pkg::cfc_ctl_t           ctl,
	input  logic                        mac_busy,
	input  logic                        out_free,
	output logic                        res_load
);
	import cfc_pkg::*;

	cfc_state_t    state_q, state_d;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] tap_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] fill_next;
	logic [AW-1:0] wp_inc;
	logic [AW-1:0] pos_dec;
	logic          idx_ok;

	assign idx_ok    = 32'(coef_index) < TAPS;
	assign fill_next = block_start ? CW'(1) :
		((fill_q < CW'(TAPS)) ? fill_q + CW'(1) : fill_q);
	assign wp_inc    = (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + AW'(1);
	assign pos_dec   = (pos_q == '0) ? AW'(TAPS - 1) : pos_q - AW'(1);
	assign dl_waddr  = wp_q;
	assign dl_raddr  = pos_q;
	assign cf_raddr  = tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wp_q    <= '0;
			tap_q   <= '0;
			pos_q   <= '0;
			clr_q   <= '0;
			fill_q  <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (dl_we) begin
				fill_q <= fill_next;
				rem_q  <= fill_next;
				tap_q  <= '0;
				pos_q  <= wp_q;
				wp_q   <= wp_inc;
			end else if (ctl.issue) begin
				rem_q <= rem_q - CW'(1);
				tap_q <= tap_q + AW'(1);
				pos_q <= pos_dec;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		dl_we     = 1'b0;
		cf_we     = 1'b0;
		cf_clear  = 1'b0;
		cf_waddr  = AW'(coef_index);
		ctl       = '0;
		res_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				// zero the coefficient store one entry a cycle
				cf_we    = 1'b1;
				cf_clear = 1'b1;
				cf_waddr = clr_q;
				if (clr_q == AW'(TAPS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == MODE_LOAD) begin
						cf_we = idx_ok;
					end else begin
						dl_we         = 1'b1;
						ctl.acc_clear = 1'b1;
						state_d       = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				ctl.issue = 1'b1;
				if (rem_q == CW'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_sample_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode == MODE_SAMPLE) |=> state_q == ST_RUN)
		else $error("sample transaction did not start the tap loop");

	a_issue_has_taps: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue |-> rem_q != '0)
		else $error("tap issued with no taps left");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TAPS))
		else $error("fill count beyond tap count");

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded over a pending transaction");

endmodule

### design/causal_fir_convolution_unit.sv
// causal_fir_convolution_unit: top level of the causal direct-form fir filter
// depends on cfc_pkg, cfc_ram, cfc_mac and cfc_ctrl
//
// channel | handshake           | payload
// --------+---------------------+----------------------------------------------
// in      | in_valid, in_ready  | mode, coef_index, value, block_start
// out     | out_valid, out_ready| filtered_sample, saturated
//
// a sample transaction steps through n taps, n being the taps in use (fill count,
// up to TAPS), on the single shared multiplier, one tap per cycle through both
// memories. after reset the coefficient store is zeroed with in_ready low.
// the output register lets a new transaction enter while a result waits.
module causal_fir_convolution_unit #(
	parameter int TAPS = cfc_pkg::DEF_TAPS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [cfc_pkg::IDX_W-1:0]       coef_index,
	input  logic [cfc_pkg::SAMPLE_BITS-1:0] value,
	input  logic                            block_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cfc_pkg::SAMPLE_BITS-1:0] filtered_sample,
	output logic                            saturated
);
	import cfc_pkg::*;

	localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int CW    = $clog2(TAPS + 1);
	localparam int ACC_W = 2 * SAMPLE_BITS + CW;

	cfc_ctl_t                 ctl;
	logic                     dl_we;
	logic [AW-1:0]            dl_waddr;
	logic [AW-1:0]            dl_raddr;
	logic                     cf_we;
	logic                     cf_clear;
	logic [AW-1:0]            cf_waddr;
	logic [AW-1:0]            cf_raddr;
	logic [SAMPLE_BITS-1:0]   cf_wdata;
	logic [SAMPLE_BITS-1:0]   dl_rdata;
	logic [SAMPLE_BITS-1:0]   cf_rdata;
	logic                     mac_busy;
	logic [SAMPLE_BITS-1:0]   mac_result;
	logic                     mac_sat;
	logic                     res_load;
	logic                     out_free;
	logic                     out_valid_q;
	logic [SAMPLE_BITS-1:0]   result_q;
	logic                     sat_q;

	assign cf_wdata = cf_clear ? '0 : value;
	assign out_free = !out_valid_q || out_ready;

	cfc_ctrl #(
		.TAPS (TAPS),
		.AW   (AW),
		.CW   (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.coef_index  (coef_index),
		.block_start (block_start),
		.dl_we       (dl_we),
		.dl_waddr    (dl_waddr),
		.dl_raddr    (dl_raddr),
		.cf_we       (cf_we),
		.cf_clear    (cf_clear),
		.cf_waddr    (cf_waddr),
		.cf_raddr    (cf_raddr),
		.ctl         (ctl),
		.mac_busy    (mac_busy),
		.out_free    (out_free),
		.res_load    (res_load)
	);

	cfc_ram #(
		.DEPTH (TAPS),
		.AW    (AW),
		.W     (SAMPLE_BITS)
	) u_delay_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (dl_waddr),
		.wdata (value),
		.raddr (dl_raddr),
		.rdata (dl_rdata)
	);

	cfc_ram #(
		.DEPTH (TAPS),
		.AW    (AW),
		.W     (SAMPLE_BITS)
	) u_coef_ram (
		.clk   (clk),
		.we    (cf_we),
		.waddr (cf_waddr),
		.wdata (cf_wdata),
		.raddr (cf_raddr),
		.rdata (cf_rdata)
	);

	cfc_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sample (dl_rdata),
		.coef   (cf_rdata),
		.busy   (mac_busy),
		.result (mac_result),
		.sat    (mac_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= mac_result;
			sat_q    <= mac_sat;
		end
	end

	assign out_valid       = out_valid_q;
	assign filtered_sample = result_q;
	assign saturated       = sat_q;

endmodule
